// File: hw/rtl/six_register_sixteen_op_cpu_unit_macros.svh
// Assertion helpers for the cpu unit. Clock clk_i, async reset rst_ni.
`ifndef SIX_REGISTER_SIXTEEN_OP_CPU_UNIT_MACROS_SVH
`define SIX_REGISTER_SIXTEEN_OP_CPU_UNIT_MACROS_SVH

// Same-cycle implication.
`define SRSOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRSOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/srsoc_pkg.sv
package srsoc_pkg;

  localparam int unsigned REGISTER_COUNT_DEF = 6;
  localparam int unsigned DATA_WIDTH_DEF     = 32;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IP_REGISTER    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH = 1'b1;

  typedef enum logic [3:0] {
    OP_ADDR = 4'd0,
    OP_ADDI = 4'd1,
    OP_MULR = 4'd2,
    OP_MULI = 4'd3,
    OP_BANR = 4'd4,
    OP_BANI = 4'd5,
    OP_BORR = 4'd6,
    OP_BORI = 4'd7,
    OP_SETR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTIR = 4'd10,
    OP_GTRI = 4'd11,
    OP_GTRR = 4'd12,
    OP_EQIR = 4'd13,
    OP_EQRI = 4'd14,
    OP_EQRR = 4'd15
  } op_e;

  typedef struct packed {
    logic [2:0]  ip_register;
    logic [15:0] program_length;
  } cfg_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [2:0]         dest_index;
  } item_t;

endpackage

// File: hw/rtl/six_register_sixteen_op_cpu_unit.sv
// Six-register instruction machine, one instruction per input beat.
// Input channel: in_valid_i / in_stall_o with opcode, operands and
// destination; each accepted beat is the instruction at the current counter.
// Output channel: out_valid_o / out_stall_i with next_pc, register 0 and
// the halted flag; exactly one result beat per input beat, in order.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0 ip_register, 1 program_length); write only while idle.
// Path: input register, then the result register that drives the output.
// Throughput: one beat per cycle unless out_stall_i holds a result; the
// input register feeds one pass of operand select, ALU (two DATA_WIDTH
// multiplies) and range compare into the result register and machine state.
// Stall: while out_stall_i holds a result, the input register keeps its
// beat and in_stall_o rises once that register is occupied.
// Once halted, beats are still taken and answered with halted set and
// unchanged counter and register 0.
// Reset: registers, counter and halted clear, ip_register 0,
// program_length 1; both channels empty.
module six_register_sixteen_op_cpu_unit #(
  parameter int unsigned REGISTER_COUNT = srsoc_pkg::REGISTER_COUNT_DEF,
  parameter int unsigned DATA_WIDTH     = srsoc_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [3:0]                        opcode_i,
  input  logic signed [31:0]                operand_a_i,
  input  logic signed [31:0]                operand_b_i,
  input  logic [2:0]                        dest_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [31:0]                next_pc_o,
  output logic signed [31:0]                first_register_o,
  output logic                              halted_o,
  input  logic                              cfg_we_i,
  input  logic [srsoc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srsoc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import srsoc_pkg::*;

  cfg_t                  cfg_q;
  item_t                 item_q;
  logic                  in_valid_q;
  logic                  out_valid_q;
  logic [31:0]           next_pc_q, first_q;
  logic                  halted_q;

  logic [DATA_WIDTH-1:0] regs_q [REGISTER_COUNT];
  logic [DATA_WIDTH-1:0] regs_d [REGISTER_COUNT];
  logic [DATA_WIDTH-1:0] pc_q, pc_d;
  logic                  stopped_q, stopped_d;
  logic [63:0]           pc_ext, r0_ext;

  logic                  adv;
  logic                  in_take;

  assign adv     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_take = in_valid_i && !in_stall_o;

  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ip_register    <= 3'd0;
      cfg_q.program_length <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IP_REGISTER:    cfg_q.ip_register    <= cfg_wdata_i[2:0];
        CFG_PROGRAM_LENGTH: cfg_q.program_length <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.opcode     <= opcode_i;
      item_q.operand_a  <= operand_a_i;
      item_q.operand_b  <= operand_b_i;
      item_q.dest_index <= dest_index_i;
    end
  end

  srsoc_exec #(
    .REGISTER_COUNT(REGISTER_COUNT),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_exec (
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .regs_i   (regs_q),
    .pc_i     (pc_q),
    .stopped_i(stopped_q),
    .regs_o   (regs_d),
    .pc_o     (pc_d),
    .stopped_o(stopped_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        regs_q[i] <= '0;
      end
      pc_q      <= '0;
      stopped_q <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        regs_q[i] <= regs_d[i];
      end
      pc_q      <= pc_d;
      stopped_q <= stopped_d;
    end
  end

  assign pc_ext = 64'(pc_d);
  assign r0_ext = 64'(regs_d[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      next_pc_q <= pc_ext[31:0];
      first_q   <= r0_ext[31:0];
      halted_q  <= stopped_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign next_pc_o        = next_pc_q;
  assign first_register_o = first_q;
  assign halted_o         = halted_q;

`include "six_register_sixteen_op_cpu_unit_macros.svh"

  `SRSOC_ASSERT_NEXT(a_halt_sticky, stopped_q, stopped_q, "halted state cleared")
  `SRSOC_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_o, "result beat lost after issue")
  `SRSOC_ASSERT_NEXT(a_halted_frozen, stopped_q && adv, halted_o && $stable(pc_q),
    "halted machine changed its counter")
  `SRSOC_ASSERT_NOW(a_stall_needs_beat, in_stall_o, in_valid_q && out_valid_q,
    "input stalled without a held beat")

endmodule

// File: hw/rtl/srsoc_exec.sv
module srsoc_exec #(
  parameter int unsigned REGISTER_COUNT = srsoc_pkg::REGISTER_COUNT_DEF,
  parameter int unsigned DATA_WIDTH     = srsoc_pkg::DATA_WIDTH_DEF
) (
  input  srsoc_pkg::cfg_t        cfg_i,
  input  srsoc_pkg::item_t       item_i,
  input  logic [DATA_WIDTH-1:0]  regs_i [REGISTER_COUNT],
  input  logic [DATA_WIDTH-1:0]  pc_i,
  input  logic                   stopped_i,
  output logic [DATA_WIDTH-1:0]  regs_o [REGISTER_COUNT],
  output logic [DATA_WIDTH-1:0]  pc_o,
  output logic                   stopped_o
);
  import srsoc_pkg::*;

  localparam int unsigned IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  function automatic logic pc_in_range(input logic [DATA_WIDTH-1:0] pc,
                                       input logic [15:0] len);
    return !pc[DATA_WIDTH-1] && (pc < DATA_WIDTH'(len));
  endfunction

  logic [DATA_WIDTH-1:0] eff [REGISTER_COUNT];
  logic [DATA_WIDTH-1:0] nxt [REGISTER_COUNT];
  logic [31:0]           ip32, a32, b32, d32;
  logic [IDX_W-1:0]      ip_idx, a_idx, b_idx, d_idx;
  logic                  ip_ok, a_ok, b_ok, d_ok;
  logic [63:0]           a_ext, b_ext;
  logic [DATA_WIDTH-1:0] ra, rb, ia, ib, res, pc_new;
  logic                  run;

  assign ip32 = 32'(cfg_i.ip_register);
  assign a32  = item_i.operand_a;
  assign b32  = item_i.operand_b;
  assign d32  = 32'(item_i.dest_index);

  assign ip_ok = ip32 < 32'(REGISTER_COUNT);
  assign a_ok  = a32 < 32'(REGISTER_COUNT);
  assign b_ok  = b32 < 32'(REGISTER_COUNT);
  assign d_ok  = d32 < 32'(REGISTER_COUNT);

  assign ip_idx = ip32[IDX_W-1:0];
  assign a_idx  = a32[IDX_W-1:0];
  assign b_idx  = b32[IDX_W-1:0];
  assign d_idx  = d32[IDX_W-1:0];

  assign a_ext = {{32{a32[31]}}, a32};
  assign b_ext = {{32{b32[31]}}, b32};
  assign ia    = a_ext[DATA_WIDTH-1:0];
  assign ib    = b_ext[DATA_WIDTH-1:0];

  assign run = !stopped_i && pc_in_range(pc_i, cfg_i.program_length);

  // counter goes into the bound register before the operands are read
  always_comb begin
    for (int i = 0; i < REGISTER_COUNT; i++) begin
      eff[i] = (ip_ok && ip_idx == IDX_W'(i)) ? pc_i : regs_i[i];
    end
  end

  assign ra = a_ok ? eff[a_idx] : '0;
  assign rb = b_ok ? eff[b_idx] : '0;

  always_comb begin
    case (op_e'(item_i.opcode))
      OP_ADDR: res = ra + rb;
      OP_ADDI: res = ra + ib;
      OP_MULR: res = ra * rb;
      OP_MULI: res = ra * ib;
      OP_BANR: res = ra & rb;
      OP_BANI: res = ra & ib;
      OP_BORR: res = ra | rb;
      OP_BORI: res = ra | ib;
      OP_SETR: res = ra;
      OP_SETI: res = ia;
      OP_GTIR: res = DATA_WIDTH'($signed(ia) > $signed(rb));
      OP_GTRI: res = DATA_WIDTH'($signed(ra) > $signed(ib));
      OP_GTRR: res = DATA_WIDTH'($signed(ra) > $signed(rb));
      OP_EQIR: res = DATA_WIDTH'(ia == rb);
      OP_EQRI: res = DATA_WIDTH'(ra == ib);
      OP_EQRR: res = DATA_WIDTH'(ra == rb);
      default: res = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < REGISTER_COUNT; i++) begin
      nxt[i] = (d_ok && d_idx == IDX_W'(i)) ? res : eff[i];
    end
  end

  assign pc_new = ip_ok ? nxt[ip_idx] + DATA_WIDTH'(1) : DATA_WIDTH'(1);

  always_comb begin
    for (int i = 0; i < REGISTER_COUNT; i++) begin
      regs_o[i] = run ? nxt[i] : regs_i[i];
    end
  end

  assign pc_o      = run ? pc_new : pc_i;
  assign stopped_o = run ? !pc_in_range(pc_new, cfg_i.program_length) : 1'b1;

endmodule
